// ----- sv/scsd_pkg.sv -----
// Shared types, constants and helper functions for the stepper command sequencer.
package scsd_pkg;

	localparam int SEQ_LEN     = 8;
	localparam int PHASE_W     = $clog2(SEQ_LEN);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPEED   = 8'h73; // 's'
	localparam logic [7:0] CH_POS     = 8'h70; // 'p'
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// Parsed delay of 32767 is stored as zero.
	localparam logic [15:0] DELAY_ALIAS = 16'h7FFF;

	typedef enum logic [1:0] {
		LETTER_OTHER,
		LETTER_SPEED,
		LETTER_POS
	} letter_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} parse_phase_t;

	typedef enum logic {
		DIR_CW,
		DIR_CCW
	} dir_t;

	// Classified transaction handed from front to back.
	typedef struct packed {
		logic       tick;
		logic       newline;
		logic       white;
		logic       sign;
		logic       minus;
		logic       digit;
		logic [3:0] digit_val;
		letter_t    letter;
	} scsd_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} scsd_q_stat_t;

	// Half-step pattern; counter-clockwise walks the same table backwards.
	function automatic logic [3:0] coil_lookup(dir_t dir, logic [PHASE_W-1:0] idx);
		logic [PHASE_W-1:0] eff;
		logic [3:0]         pat;
		eff = (dir == DIR_CCW) ? ~idx : idx;
		unique case (eff)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h0;
		endcase
		return pat;
	endfunction

	function automatic logic [15:0] hold_ticks(logic [15:0] d);
		return (d == 16'd0) ? 16'd1 : d;
	endfunction

endpackage

// ----- sv/scsd_if.sv -----
// Valid/ready channel interfaces for the command and status streams.
interface scsd_cmd_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface scsd_stat_if;
	logic               valid;
	logic               ready;
	logic [3:0]         coil_pattern;
	logic               moving;
	logic signed [15:0] current_position;
	logic signed [15:0] target_position;
	logic [15:0]        step_delay;
	logic               line_done;

	modport source (
		output valid, output coil_pattern, output moving, output current_position,
		output target_position, output step_delay, output line_done, input ready
	);
	modport sink (
		input valid, input coil_pattern, input moving, input current_position,
		input target_position, input step_delay, input line_done, output ready
	);
endinterface

// ----- sv/scsd_front.sv -----
// Front end: accepts command transactions and classifies bytes for the back end.
module scsd_front import scsd_pkg::*; (
	scsd_cmd_if.sink     cmd,
	input  scsd_q_stat_t q_stat,
	output logic         q_push,
	output scsd_item_t   q_item
);

	logic [7:0] b;

	assign b          = cmd.rx_byte;
	assign cmd.ready  = !q_stat.full;
	assign q_push     = cmd.valid && !q_stat.full;

	always_comb begin
		q_item           = '0;
		q_item.tick      = cmd.mode;
		q_item.newline   = (b == CH_NEWLINE);
		// space, TAB, LF, VT, FF, CR
		q_item.white     = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
		q_item.sign      = (b == CH_MINUS) || (b == CH_PLUS);
		q_item.minus     = (b == CH_MINUS);
		q_item.digit     = (b >= CH_ZERO) && (b <= CH_NINE);
		q_item.digit_val = 4'(b - CH_ZERO);
		unique case (b)
			CH_SPEED: q_item.letter = LETTER_SPEED;
			CH_POS:   q_item.letter = LETTER_POS;
			default:  q_item.letter = LETTER_OTHER;
		endcase
	end

endmodule

// ----- sv/scsd_queue.sv -----
// Two-entry queue between the front and back ends.
module scsd_queue import scsd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  scsd_item_t   push_item,
	input  logic         pop,
	output scsd_item_t   head,
	output scsd_q_stat_t stat
);

	scsd_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= QCNT_W'(count_q + QCNT_W'(push) - QCNT_W'(pop));
		end
	end

endmodule

// ----- sv/scsd_back.sv -----
// Back end: line parser, motion sequencer and the status register.
module scsd_back import scsd_pkg::*; #(
	parameter int LINE_CHARS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  scsd_item_t   head,
	input  scsd_q_stat_t q_stat,
	output logic         pop,
	scsd_stat_if.source  status
);

	localparam int LC_W = $clog2(LINE_CHARS + 1);

	// line parser
	logic [LC_W-1:0] lc_q, lc_n;
	letter_t         letter_q, letter_n;
	parse_phase_t    phase_q, phase_n;
	logic            neg_q, neg_n;
	logic [15:0]     acc_q, acc_n;
	// commanded values
	logic [15:0]     target_q, target_n;
	logic [15:0]     delay_q, delay_n;
	logic [15:0]     pos_q, pos_n;
	// motion
	logic [15:0]        lat_target_q, lat_target_n;
	logic [15:0]        lat_delay_q, lat_delay_n;
	logic [15:0]        rem_q, rem_n;
	dir_t               dir_q, dir_n;
	logic [PHASE_W-1:0] idx_q, idx_n;
	logic [15:0]        hold_q, hold_n;
	logic               busy_q, busy_n;
	logic [3:0]         coil_q, coil_n;
	// status handshake
	logic               valid_q;
	logic               done_q, done_n;

	logic [15:0]        diff, value, acc_x10, hold_dec, rem_dec;
	logic [PHASE_W-1:0] idx_inc;
	dir_t               start_dir;

	assign pop       = !q_stat.empty && (!valid_q || status.ready);
	assign diff      = 16'(target_q - pos_q);
	assign start_dir = diff[15] ? DIR_CCW : DIR_CW;
	assign value     = neg_q ? 16'(16'd0 - acc_q) : acc_q;
	assign acc_x10   = 16'({acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'd0, head.digit_val});
	assign hold_dec  = (hold_q != 16'd0) ? 16'(hold_q - 16'd1) : hold_q;
	assign rem_dec   = 16'(rem_q - 16'd1);
	assign idx_inc   = PHASE_W'(idx_q + 1'b1);

	always_comb begin
		lc_n         = lc_q;
		letter_n     = letter_q;
		phase_n      = phase_q;
		neg_n        = neg_q;
		acc_n        = acc_q;
		target_n     = target_q;
		delay_n      = delay_q;
		pos_n        = pos_q;
		lat_target_n = lat_target_q;
		lat_delay_n  = lat_delay_q;
		rem_n        = rem_q;
		dir_n        = dir_q;
		idx_n        = idx_q;
		hold_n       = hold_q;
		busy_n       = busy_q;
		coil_n       = coil_q;
		done_n       = done_q;

		if (pop) begin
			done_n = !head.tick && head.newline;
			if (head.tick) begin
				if (!busy_q) begin
					if (diff != 16'd0) begin
						lat_target_n = target_q;
						lat_delay_n  = delay_q;
						dir_n        = start_dir;
						rem_n        = diff[15] ? 16'(16'd0 - diff) : diff;
						idx_n        = '0;
						coil_n       = coil_lookup(start_dir, '0);
						hold_n       = hold_ticks(delay_q);
						busy_n       = 1'b1;
					end
				end else if (hold_dec != 16'd0) begin
					hold_n = hold_dec;
				end else begin
					hold_n = hold_dec;
					idx_n  = idx_inc;
					if (idx_inc == '0 && rem_dec == 16'd0) begin
						// last pattern of the last cycle: motion complete, coils keep pattern
						rem_n  = rem_dec;
						busy_n = 1'b0;
						pos_n  = lat_target_q;
					end else begin
						if (idx_inc == '0) begin
							rem_n = rem_dec;
						end
						coil_n = coil_lookup(dir_q, idx_inc);
						hold_n = hold_ticks(lat_delay_q);
					end
				end
			end else if (head.newline) begin
				if (lc_q != '0) begin
					case (letter_q)
						LETTER_SPEED: delay_n  = (value == DELAY_ALIAS) ? 16'd0 : value;
						LETTER_POS:   target_n = value;
						default:      ;
					endcase
				end
				lc_n     = '0;
				letter_n = LETTER_OTHER;
				phase_n  = PH_SKIP;
				neg_n    = 1'b0;
				acc_n    = '0;
			end else if (lc_q < LC_W'(LINE_CHARS)) begin
				lc_n = LC_W'(lc_q + 1'b1);
				if (lc_q == '0) begin
					letter_n = head.letter;
				end else if (phase_q == PH_SKIP && head.white) begin
					phase_n = PH_SKIP;
				end else if (phase_q == PH_SKIP && head.sign) begin
					neg_n   = head.minus;
					phase_n = PH_DIGITS;
				end else if (phase_q == PH_SKIP || phase_q == PH_DIGITS) begin
					if (head.digit) begin
						acc_n   = acc_x10;
						phase_n = PH_DIGITS;
					end else begin
						phase_n = PH_DONE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q         <= '0;
			letter_q     <= LETTER_OTHER;
			phase_q      <= PH_SKIP;
			neg_q        <= 1'b0;
			acc_q        <= '0;
			target_q     <= '0;
			delay_q      <= '0;
			pos_q        <= '0;
			lat_target_q <= '0;
			lat_delay_q  <= '0;
			rem_q        <= '0;
			dir_q        <= DIR_CW;
			idx_q        <= '0;
			hold_q       <= '0;
			busy_q       <= 1'b0;
			coil_q       <= '0;
			done_q       <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			lc_q         <= lc_n;
			letter_q     <= letter_n;
			phase_q      <= phase_n;
			neg_q        <= neg_n;
			acc_q        <= acc_n;
			target_q     <= target_n;
			delay_q      <= delay_n;
			pos_q        <= pos_n;
			lat_target_q <= lat_target_n;
			lat_delay_q  <= lat_delay_n;
			rem_q        <= rem_n;
			dir_q        <= dir_n;
			idx_q        <= idx_n;
			hold_q       <= hold_n;
			busy_q       <= busy_n;
			coil_q       <= coil_n;
			done_q       <= done_n;
			if (pop) begin
				valid_q <= 1'b1;
			end else if (status.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// State only moves on a pop, so it doubles as the held status payload.
	assign status.valid            = valid_q;
	assign status.coil_pattern     = coil_q;
	assign status.moving           = busy_q;
	assign status.current_position = $signed(pos_q);
	assign status.target_position  = $signed(target_q);
	assign status.step_delay       = delay_q;
	assign status.line_done        = done_q;

	a_hold_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> hold_q != 16'd0)
		else $error("hold counter zero during motion");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != 16'd0)
		else $error("no cycles left during motion");

	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> pos_q == lat_target_q)
		else $error("position not at latched target after motion");

	a_line_len: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= LC_W'(LINE_CHARS))
		else $error("line length past limit");

	a_no_change_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !status.ready) |=> $stable(pos_q) && $stable(coil_q) && valid_q)
		else $error("status changed while stalled");

endmodule

// ----- sv/stepper_command_half_step_driver_top.sv -----
// Top level of the half-step stepper command sequencer.
//
//   channel  dir  handshake            payload
//   cmd      in   cmd.valid/cmd.ready  mode, rx_byte
//   status   out  status.valid/ready   coil_pattern, moving, current_position,
//                                      target_position, step_delay, line_done
//
// Sustained rate is one transaction per clock on both channels while status.ready stays high.
// A status transaction appears once its command has passed through the two-entry
// queue and then the back-end state update.
// Reset clears every register but the queue storage; no clearing pass, cmd.ready is high right after.
// A status stall freezes the back end; the queue absorbs two commands, then
// cmd.ready drops until status.ready returns.
module stepper_command_half_step_driver_top import scsd_pkg::*; #(
	parameter int LINE_CHARS = 6
) (
	input logic         clk,
	input logic         arst_n,
	scsd_cmd_if.sink    cmd,
	scsd_stat_if.source status
);

	scsd_item_t   push_item;
	scsd_item_t   head;
	scsd_q_stat_t q_stat;
	logic         push;
	logic         pop;

	// front: byte classification and input handshake
	scsd_front u_front (
		.cmd    (cmd),
		.q_stat (q_stat),
		.q_push (push),
		.q_item (push_item)
	);

	// decouples acceptance from execution
	scsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// back: line parser, motion sequencer, status register
	scsd_back #(
		.LINE_CHARS (LINE_CHARS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.status (status)
	);

endmodule
